FILE: hw/rtl/cltm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_pkg - shared types and constants of the command line tokenizer/matcher
// Holds the command name table, status codes and the result word layout.
// ----------------------------------------------------------------------------
package cltm_pkg;

  localparam int unsigned NAME_COUNT = 10;
  localparam int unsigned NAME_BITS  = 128;  // 16 character slots per name
  localparam int unsigned IN_W       = 8;
  localparam int unsigned OUT_W      = 16;   // 9 payload bits padded to bytes

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_ARG_ERROR = 2'd2;

  // names sit right-justified: first character in the highest used byte
  localparam logic [NAME_BITS-1:0] NAME_TEXT [NAME_COUNT] = '{
    NAME_BITS'("iiccheck"), NAME_BITS'("iicread"),  NAME_BITS'("iicwrite"),
    NAME_BITS'("iicread16"), NAME_BITS'("iicwrite16"), NAME_BITS'("enserial"),
    NAME_BITS'("flashprog"), NAME_BITS'("mario"),    NAME_BITS'("deadline"),
    NAME_BITS'("alarm")
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd8, 4'd7, 4'd8, 4'd9, 4'd10, 4'd8, 4'd9, 4'd5, 4'd8, 4'd5
  };

  typedef struct packed {
    logic [2:0] arg_count;
    logic [3:0] command_index;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_out_t;

  // character k of name n, valid for k below the name length
  function automatic logic [7:0] name_byte(input int unsigned n, input logic [3:0] k);
    logic [3:0] slot;
    slot = NAME_LEN[n] - 4'd1 - k;
    return NAME_TEXT[n][{slot, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cltm_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_step - one character of tokenizer and matcher update
// Next line state and the optional result word for a single character.
// ----------------------------------------------------------------------------
module cltm_step import cltm_pkg::*; #(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 16,
  localparam int unsigned TOK_W = $clog2(MAX_TOKENS + 1),
  localparam int unsigned POS_W = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  wire logic [7:0]            char_i,
  input  wire logic [TOK_W-1:0]      tok_i,
  input  wire logic [POS_W-1:0]      pos_i,
  input  wire logic [NAME_COUNT-1:0] flags_i,
  input  wire logic                  err_i,
  output logic      [TOK_W-1:0]      tok_o,
  output logic      [POS_W-1:0]      pos_o,
  output logic      [NAME_COUNT-1:0] flags_o,
  output logic                       err_o,
  output step_out_t                  out_o
);

  logic [NAME_COUNT-1:0] len_hit;
  logic [NAME_COUNT-1:0] char_hit;
  logic [NAME_COUNT-1:0] flags_len;
  logic [NAME_COUNT-1:0] final_flags;
  logic [3:0]            hit_index;
  logic [TOK_W-1:0]      tok_inc;
  logic [POS_W-1:0]      pos_inc;
  logic                  is_term;
  logic                  first_tok;

  assign is_term   = (char_i == CHAR_LF) || (char_i == CHAR_NUL);
  assign first_tok = (tok_i == '0);
  assign tok_inc   = tok_i + TOK_W'(1);
  assign pos_inc   = pos_i + POS_W'(1);

  // per-name compares, all in parallel
  always_comb begin
    for (int n = 0; n < NAME_COUNT; n++) begin
      len_hit[n]  = (pos_i == POS_W'(NAME_LEN[n]));
      char_hit[n] = (pos_i < POS_W'(NAME_LEN[n])) && (name_byte(n, pos_i[3:0]) == char_i);
    end
  end

  assign flags_len   = flags_i & len_hit;
  assign final_flags = first_tok ? flags_len : flags_i;

  // lowest surviving name wins
  always_comb begin
    hit_index = '0;
    for (int n = NAME_COUNT - 1; n >= 0; n--) begin
      if (final_flags[n]) begin
        hit_index = 4'(n);
      end
    end
  end

  always_comb begin
    tok_o              = tok_i;
    pos_o              = pos_i;
    flags_o            = flags_i;
    err_o              = err_i;
    out_o.emit         = 1'b0;
    out_o.res.status   = STATUS_NOT_FOUND;
    out_o.res.command_index = '0;
    out_o.res.arg_count     = '0;
    if (is_term) begin
      out_o.emit = 1'b1;
      if (err_i) begin
        out_o.res.status = STATUS_ARG_ERROR;
      end else if (|final_flags) begin
        out_o.res.status        = STATUS_FOUND;
        out_o.res.command_index = hit_index;
        out_o.res.arg_count     = 3'(tok_i);
      end
      tok_o   = '0;
      pos_o   = '0;
      flags_o = '1;
      err_o   = 1'b0;
    end else if (!err_i) begin
      if (char_i == CHAR_SPACE) begin
        if (pos_i != '0) begin
          if (first_tok) begin
            flags_o = flags_len;
          end
          tok_o = tok_inc;
          if (tok_inc >= TOK_W'(MAX_TOKENS)) begin
            err_o = 1'b1;
          end
        end
        pos_o = '0;
      end else begin
        if (first_tok) begin
          flags_o = flags_i & char_hit;
        end
        pos_o = pos_inc;
        if (pos_inc >= POS_W'(MAX_TOKEN_LEN)) begin
          err_o = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/command_line_tokenizer_matcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer_matcher_core - command line tokenizer and name matcher
// Splits a character stream into space-separated tokens and matches the first
// token against a fixed table of ten command names.
// ----------------------------------------------------------------------------
// One character word enters per cycle. Each accepted word is held in an input
// register until it advances, then the tokenizer state (token index, character
// position, ten name match flags, error flag) is updated by a single level of
// parallel compares and counter increments. A newline or NUL ends the line and
// writes one result word into the output register as it leaves the input
// register; all other characters produce nothing. Sustained rate is one
// character per cycle. The output register only stalls the pipe when a line
// terminator meets a result that has not yet been taken; ordinary characters
// keep flowing past a waiting result. There are no configuration registers.
// ----------------------------------------------------------------------------
module command_line_tokenizer_matcher_core import cltm_pkg::*; #(
  parameter int unsigned MAX_TOKENS    = 8,   // 2 .. 8
  parameter int unsigned MAX_TOKEN_LEN = 16   // 11 .. 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // character stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,   // [7:0] line_char
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_W-1:0]  m_axis_tdata    // [1:0] status, [5:2] command_index,
                                                 // [8:6] arg_count, [15:9] zero
);

  localparam int unsigned TOK_W = $clog2(MAX_TOKENS + 1);
  localparam int unsigned POS_W = $clog2(MAX_TOKEN_LEN + 1);

  // input register
  logic                  in_valid_q, in_valid_d;
  logic [7:0]            in_char_q,  in_char_d;

  // line state
  logic [TOK_W-1:0]      tok_q,   tok_d;
  logic [POS_W-1:0]      pos_q,   pos_d;
  logic [NAME_COUNT-1:0] flags_q, flags_d;
  logic                  err_q,   err_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  result_t               out_q,       out_d;

  step_out_t             step_out;
  logic                  out_free;
  logic                  advance;
  logic                  in_accept;

  cltm_step #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_step (
    .char_i  (in_char_q),
    .tok_i   (tok_q),
    .pos_i   (pos_q),
    .flags_i (flags_q),
    .err_i   (err_q),
    .tok_o   (tok_d),
    .pos_o   (pos_d),
    .flags_o (flags_d),
    .err_o   (err_d),
    .out_o   (step_out)
  );

  // a terminator needs a free output slot, any other character moves on
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!step_out.emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_char_d  = in_char_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance && step_out.emit) begin
      out_valid_d = 1'b1;
      out_d       = step_out.res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tok_q       <= '0;
      pos_q       <= '0;
      flags_q     <= '1;
      err_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        tok_q   <= tok_d;
        pos_q   <= pos_d;
        flags_q <= flags_d;
        err_q   <= err_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_q.arg_count, out_q.command_index, out_q.status});

endmodule
`default_nettype wire

FILE: hw/rtl/cltm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cltm_checker - port-level checks of the tokenizer/matcher
// Watches the result stream for protocol and encoding slips.
// ----------------------------------------------------------------------------
module cltm_checker import cltm_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_FOUND) ||
                      (m_axis_tdata[1:0] == STATUS_NOT_FOUND) ||
                      (m_axis_tdata[1:0] == STATUS_ARG_ERROR))
    else $error("undefined status code");

  // miss or error carries zero index and count
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != STATUS_FOUND)
      |-> (m_axis_tdata[5:2] == 4'd0) && (m_axis_tdata[8:6] == 3'd0))
    else $error("index or count set without a match");

  // a hit points into the name table, padding stays zero
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:2] < 4'(NAME_COUNT)) &&
                      (m_axis_tdata[OUT_W-1:9] == '0))
    else $error("command index out of table or padding set");

endmodule

bind command_line_tokenizer_matcher_core cltm_checker u_cltm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
